// File: design/stb_pkg.sv
// Shared types and constants for the sleep timer bank.
package stb_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam logic [1:0]  MODE_TICK  = 2'd0;
   localparam logic [1:0]  MODE_RAW   = 2'd1;
   localparam logic [1:0]  MODE_MS    = 2'd2;
   localparam logic [1:0]  MODE_QUERY = 2'd3;

   localparam logic [15:0] TPU_RESET  = 16'd1;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] amount;
      logic [3:0]  slot_select;
   } req_type;

   typedef struct packed {
      logic [3:0]  slot_index;
      logic        bank_full;
      logic        expired;
      logic [31:0] remaining;
   } rsp_type;

endpackage

// File: design/sleep_timer_bank_core.sv
// Sleep timer bank: countdown slots walked by one shared decrement/compare unit.
//
// The req_ channel takes one item at a time: a tick, a registration in raw
// ticks or milliseconds, or a query of one slot. Every item gives exactly one
// item on the rsp_ channel. req_stall is high while an item is being worked.
// The csr_ port writes ticks_per_unit whenever csr_we is high.
//
// Slot counts sit in a memory with one registered read port and one write
// port. A tick or registration walks the slots one per cycle, reading slot
// k+1 while slot k is evaluated and written back. A tick walks every slot
// before rsp_valid; a registration first passes ST_LOAD to form the load
// value, then walks and ends early at the first free slot; a query passes
// ST_QRD and ST_QEV, or goes straight to ST_DONE for a slot beyond the bank.
// No new item is taken until the last one has left ST_DONE, so the slot
// walk sets the rate.
//
// Reset clears the valid bit of every slot at once, so all slots read as free,
// and sets ticks_per_unit to 1. A result waits in the output register while
// rsp_stall is high; the next item is accepted meanwhile and its result is
// held inside until the output register frees up.
module sleep_timer_bank_core #(
   parameter int SLOT_COUNT = stb_pkg::SLOT_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stb_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stb_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PTR_W = IDX_W + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_QRD  = 3'd3;
   localparam logic [2:0] ST_QEV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       sel_ff, sel_in;
   logic [47:0]      prod_ff, prod_in;
   logic [31:0]      load_ff, load_in;
   logic [31:0]      sat_val;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] ev_ptr_ff, ev_ptr_in;
   logic             ev_live_ff, ev_live_in;
   logic [31:0]      rd_data_ff;
   logic             rd_vld_ff;
   logic [31:0]      cur;
   logic             last_slot;
   logic             wr_en;
   logic [31:0]      wr_data;
   logic [15:0]      tpu_ff;
   stb_pkg::rsp_type res_ff, res_in;
   stb_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [31:0]      slot_mem [SLOT_COUNT];
   logic             slot_vld_ff [SLOT_COUNT];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A slot never written since reset reads as zero.
   assign cur       = rd_vld_ff ? rd_data_ff : 32'd0;
   assign last_slot = (ev_ptr_ff == IDX_W'(SLOT_COUNT - 1));
   assign sat_val   = (prod_ff[47:32] != 16'd0) ? stb_pkg::COUNT_MAX : prod_ff[31:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sel_in       = sel_ff;
      prod_in      = prod_ff;
      load_in      = load_ff;
      rd_ptr_in    = rd_ptr_ff;
      ev_ptr_in    = ev_ptr_ff;
      ev_live_in   = 1'b0;
      wr_en        = 1'b0;
      wr_data      = 32'd0;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_item.mode;
               sel_in    = req_item.slot_select;
               res_in    = '0;
               rd_ptr_in = '0;
               case (req_item.mode)
                  stb_pkg::MODE_TICK: begin
                     state_in = ST_WALK;
                  end
                  stb_pkg::MODE_RAW: begin
                     prod_in  = {16'd0, req_item.amount};
                     state_in = ST_LOAD;
                  end
                  stb_pkg::MODE_MS: begin
                     prod_in  = 48'(req_item.amount) * 48'(tpu_ff);
                     state_in = ST_LOAD;
                  end
                  default: begin
                     if (32'(req_item.slot_select) < 32'(SLOT_COUNT)) begin
                        rd_ptr_in = PTR_W'(req_item.slot_select);
                        state_in  = ST_QRD;
                     end else begin
                        res_in.slot_index = req_item.slot_select;
                        res_in.expired    = 1'b1;
                        state_in          = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            load_in  = (sat_val == 32'd0) ? 32'd1 : sat_val;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rd_ptr_ff < PTR_W'(SLOT_COUNT)) begin
               rd_ptr_in  = rd_ptr_ff + PTR_W'(1);
               ev_ptr_in  = rd_ptr_ff[IDX_W-1:0];
               ev_live_in = 1'b1;
            end
            if (ev_live_ff) begin
               if (mode_ff == stb_pkg::MODE_TICK) begin
                  if (cur != 32'd0) begin
                     wr_en   = 1'b1;
                     wr_data = cur - 32'd1;
                  end
                  if (last_slot) begin
                     state_in = ST_DONE;
                  end
               end else if (cur == 32'd0) begin
                  wr_en             = 1'b1;
                  wr_data           = load_ff;
                  res_in.slot_index = 4'(ev_ptr_ff);
                  res_in.remaining  = load_ff;
                  state_in          = ST_DONE;
               end else if (last_slot) begin
                  res_in.bank_full = 1'b1;
                  state_in         = ST_DONE;
               end
            end
         end
         ST_QRD: begin
            state_in = ST_QEV;
         end
         ST_QEV: begin
            res_in.slot_index = sel_ff;
            res_in.expired    = (cur == 32'd0);
            res_in.remaining  = cur;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tpu_ff       <= stb_pkg::TPU_RESET;
      end else begin
         state_ff     <= state_in;
         ev_live_ff   <= ev_live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            tpu_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      sel_ff    <= sel_in;
      prod_ff   <= prod_in;
      load_ff   <= load_in;
      rd_ptr_ff <= rd_ptr_in;
      ev_ptr_ff <= ev_ptr_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   // Slot memory: one registered read, one write at the slot being evaluated.
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_ptr_ff[IDX_W-1:0]];
      if (wr_en) begin
         slot_mem[ev_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_vld_ff[i] <= 1'b0;
         end
      end else begin
         rd_vld_ff <= slot_vld_ff[rd_ptr_ff[IDX_W-1:0]];
         if (wr_en) begin
            slot_vld_ff[ev_ptr_ff] <= 1'b1;
         end
      end
   end

`ifndef SYNTH
   a_tick_walks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.mode == stb_pkg::MODE_TICK)
      |=> (state_ff == ST_WALK && !ev_live_ff))
      else $error("tick item did not start a slot walk");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.bank_full)
      |-> (rsp_item.remaining == 32'd0 && rsp_item.slot_index == 4'd0 && !rsp_item.expired))
      else $error("bank full result carries slot data");

   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.expired) |-> (rsp_item.remaining == 32'd0))
      else $error("expired slot reported a nonzero count");

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_WALK && ev_live_ff))
      else $error("slot write outside a walk");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the sleep timer bank core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = stb_pkg::SLOT_COUNT_DEF;

   typedef enum {PLAN_ITEM, PLAN_CSR, PLAN_DRAIN} plan_kind_type;

   typedef struct {
      plan_kind_type    kind;
      stb_pkg::req_type item;
      logic [15:0]      scale;
   } plan_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   stb_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   stb_pkg::rsp_type rsp_item;
   logic             csr_we = 1'b0;
   logic [15:0]      csr_wdata = '0;

   plan_entry_type   plan_q[$];
   stb_pkg::rsp_type due_q[$];

   // Timer state and scale as the block should hold them.
   logic [31:0] slot_left [SLOTS];
   logic [15:0] tick_scale;

   bit          req_taken = 1'b0;
   bit          stim_done = 1'b0;
   int          n_accepted = 0;
   int          n_bad = 0;
   int          hold_left = 0;
   int          hold_mark = 350;
   bit          calm;

   sleep_timer_bank_core #(.SLOT_COUNT(SLOTS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // No random idling on either side while this window of items passes.
   assign calm = (n_accepted >= 600) && (n_accepted < 800);

   function automatic stb_pkg::rsp_type timer_bank_next(stb_pkg::req_type r);
      stb_pkg::rsp_type o;
      logic [63:0]      prod;
      logic [31:0]      load;
      bit               found;
      o = '0;
      case (r.mode)
         stb_pkg::MODE_TICK: begin
            foreach (slot_left[i]) begin
               if (slot_left[i] != 0) slot_left[i] = slot_left[i] - 1;
            end
         end
         stb_pkg::MODE_QUERY: begin
            o.slot_index = r.slot_select;
            if (int'(r.slot_select) < SLOTS) begin
               o.remaining = slot_left[r.slot_select];
               o.expired = (slot_left[r.slot_select] == 0);
            end else begin
               o.expired = 1'b1;
            end
         end
         default: begin
            if (r.mode == stb_pkg::MODE_MS) begin
               prod = 64'(r.amount) * 64'(tick_scale);
               load = (prod > 64'(stb_pkg::COUNT_MAX)) ? stb_pkg::COUNT_MAX : prod[31:0];
            end else begin
               load = r.amount;
            end
            if (load == 0) load = 1;
            found = 1'b0;
            for (int i = 0; i < SLOTS && !found; i++) begin
               if (slot_left[i] == 0) begin
                  slot_left[i] = load;
                  o.slot_index = 4'(i);
                  o.remaining = load;
                  found = 1'b1;
               end
            end
            if (!found) o.bank_full = 1'b1;
         end
      endcase
      return o;
   endfunction

   task automatic plan_item(logic [1:0] mode, logic [31:0] amount, logic [3:0] sel);
      plan_entry_type e;
      e.kind = PLAN_ITEM;
      e.item.mode = mode;
      e.item.amount = amount;
      e.item.slot_select = sel;
      e.scale = '0;
      plan_q.push_back(e);
   endtask

   task automatic plan_write(plan_kind_type kind, logic [15:0] scale);
      plan_entry_type e;
      e.kind = kind;
      e.item = '0;
      e.scale = scale;
      plan_q.push_back(e);
   endtask

   // Driver: inputs move on the falling edge; a stalled item is held as it is.
   always @(negedge clock) begin
      bit             nxt_valid;
      bit             nxt_we;
      bit             idle;
      plan_entry_type e;
      if (!reset && !(req_valid && !req_taken)) begin
         nxt_valid = 1'b0;
         nxt_we = 1'b0;
         idle = (due_q.size() == 0);
         if (plan_q.size() > 0) begin
            e = plan_q[0];
            case (e.kind)
               PLAN_ITEM: begin
                  if (calm || $urandom_range(0, 99) >= 11) begin
                     nxt_valid = 1'b1;
                     req_item <= e.item;
                     void'(plan_q.pop_front());
                  end
               end
               PLAN_CSR: begin
                  if (idle) begin
                     nxt_we = 1'b1;
                     csr_wdata <= e.scale;
                     void'(plan_q.pop_front());
                  end
               end
               default: begin
                  if (idle) void'(plan_q.pop_front());
               end
            endcase
         end else if (idle) begin
            stim_done = 1'b1;
         end
         req_valid <= nxt_valid;
         csr_we <= nxt_we;
      end
   end

   // Receiver stall, with a long hold-off now and then so the block backs up.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (n_accepted >= hold_mark) begin
         rsp_stall <= 1'b1;
         hold_left <= 150;
         hold_mark <= hold_mark + 650;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
   end

   // Monitor: everything is sampled on the rising edge.
   always @(posedge clock) begin
      stb_pkg::rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_we) tick_scale = csr_wdata;
         if (req_taken) begin
            due_q.push_back(timer_bank_next(req_item));
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("unexpected result item: idx %0d full %0b exp %0b rem %0h",
                           rsp_item.slot_index, rsp_item.bank_full, rsp_item.expired,
                           rsp_item.remaining);
            end else begin
               want = due_q.pop_front();
               if (rsp_item.slot_index !== want.slot_index ||
                   rsp_item.bank_full !== want.bank_full ||
                   rsp_item.expired !== want.expired ||
                   rsp_item.remaining !== want.remaining) begin
                  n_bad++;
                  if (n_bad <= 10) begin
                     $display("mismatch: want idx %0d full %0b exp %0b rem %0h",
                              want.slot_index, want.bank_full, want.expired,
                              want.remaining);
                     $display("          got  idx %0d full %0b exp %0b rem %0h",
                              rsp_item.slot_index, rsp_item.bank_full, rsp_item.expired,
                              rsp_item.remaining);
                  end
               end
            end
         end
      end
   end

   initial begin
      int          n_reg;
      int          big_left;
      int          phase;
      logic [15:0] plan_scale;
      logic [31:0] amt;
      logic [1:0]  mode;

      foreach (slot_left[i]) slot_left[i] = '0;
      tick_scale = stb_pkg::TPU_RESET;

      // Directed opening: empty bank, zero loads, extremes, saturation, full bank.
      plan_item(stb_pkg::MODE_TICK, stb_pkg::COUNT_MAX, 4'd15);
      plan_item(stb_pkg::MODE_QUERY, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_RAW, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_MS, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_QUERY, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_TICK, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_RAW, stb_pkg::COUNT_MAX, 4'd0);
      plan_item(stb_pkg::MODE_MS, 32'd7, 4'd0);
      plan_write(PLAN_CSR, 16'hFFFF);
      plan_item(stb_pkg::MODE_MS, stb_pkg::COUNT_MAX, 4'd0);
      plan_item(stb_pkg::MODE_MS, 32'd1, 4'd0);
      plan_item(stb_pkg::MODE_MS, 32'd0, 4'd0);
      plan_item(stb_pkg::MODE_QUERY, 32'd0, 4'd2);
      plan_item(stb_pkg::MODE_QUERY, 32'd0, 4'd3);
      plan_item(stb_pkg::MODE_TICK, 32'd0, 4'd0);
      plan_write(PLAN_CSR, stb_pkg::TPU_RESET);
      // Slot 4 and up are free now: fill them all, then one more hits a full bank.
      repeat (12) plan_item(stb_pkg::MODE_RAW, 32'd2, 4'd0);
      plan_item(stb_pkg::MODE_RAW, 32'd5, 4'd0);
      plan_item(stb_pkg::MODE_QUERY, stb_pkg::COUNT_MAX, 4'd15);

      // Random part: bursts of registrations, queries and ticks that expire them.
      plan_scale = stb_pkg::TPU_RESET;
      big_left = 3;
      phase = 0;
      while (plan_q.size() < 1280) begin
         if (phase == 0 && plan_q.size() >= 320) begin
            plan_scale = 16'hFFFF;
            plan_write(PLAN_CSR, plan_scale);
            phase = 1;
         end else if (phase == 1 && plan_q.size() >= 480) begin
            plan_write(PLAN_DRAIN, '0);
            phase = 2;
         end else if (phase == 2 && plan_q.size() >= 640) begin
            plan_scale = 16'($urandom_range(2, 6));
            plan_write(PLAN_CSR, plan_scale);
            phase = 3;
         end else if (phase == 3 && plan_q.size() >= 960) begin
            plan_scale = 16'($urandom_range(7, 65534));
            plan_write(PLAN_CSR, plan_scale);
            phase = 4;
         end
         n_reg = $urandom_range(1, 14);
         repeat (n_reg) begin
            if ($urandom_range(0, 99) < 70) begin
               mode = stb_pkg::MODE_RAW;
               amt = $urandom_range(0, 14);
               if (big_left > 0 && $urandom_range(0, 99) == 0) begin
                  big_left--;
                  amt = $urandom();
               end
            end else begin
               mode = stb_pkg::MODE_MS;
               // A large scale would pin a slot forever, so such amounts stay rare.
               if (plan_scale <= 6) amt = $urandom_range(0, 4);
               else if (big_left > 0 && $urandom_range(0, 19) == 0) begin
                  big_left--;
                  amt = $urandom_range(1, 3);
               end else amt = 32'd0;
            end
            plan_item(mode, amt, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 99) < 30)
               plan_item(stb_pkg::MODE_QUERY, $urandom(), 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 99) < 10)
               plan_item(stb_pkg::MODE_TICK, $urandom(), 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 99) < 8) begin
               mode = 2'($urandom_range(0, 3));
               amt = (mode == stb_pkg::MODE_RAW) ? 32'($urandom_range(0, 30)) :
                     (mode == stb_pkg::MODE_MS) ? 32'd0 : 32'($urandom());
               plan_item(mode, amt, 4'($urandom_range(0, 15)));
            end
         end
         repeat ($urandom_range(3, 16)) begin
            plan_item(stb_pkg::MODE_TICK, $urandom(), 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 99) < 35)
               plan_item(stb_pkg::MODE_QUERY, $urandom(), 4'($urandom_range(0, 15)));
         end
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      wait (stim_done);
      repeat (40) @(posedge clock);
      if (n_bad == 0 && due_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
